/* rtl/core/i2cee_pkg.sv */
`timescale 1ns / 1ps

package i2cee_pkg;

  // memory size is a power of two so that address wrap is a plain truncation
  localparam int unsigned MemBytes   = 8192;
  localparam int unsigned AddrW      = $clog2(MemBytes);
  localparam int unsigned RxBufBytes = 64;
  localparam int unsigned IdxW       = $clog2(RxBufBytes);
  localparam int unsigned CntW       = $clog2(RxBufBytes + 1);
  localparam int unsigned AddrBytes  = 2;

  localparam logic [7:0] ErasedByte = 8'hFF;

  typedef enum logic [2:0] {
    OP_WR_START = 3'd0,
    OP_RD_START = 3'd1,
    OP_BYTE_RX  = 3'd2,
    OP_BYTE_TX  = 3'd3,
    OP_STOP     = 3'd4
  } op_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic            re;
    logic [IdxW-1:0] raddr;
    logic [7:0]      wdata;
  } rxb_req_t;

endpackage

/* rtl/core/i2cee_store.sv */
`timescale 1ns / 1ps

module i2cee_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  i2cee_pkg::mem_req_t          req_i,
  output logic [7:0]                   rdata_o,
  output logic                         init_done_o
);
  import i2cee_pkg::*;

  logic [7:0]       mem [MemBytes];
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;
  logic [7:0]       rdata_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  // erase sweep after reset, one byte per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(MemBytes - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = ErasedByte;
    end else begin
      wr_en   = req_i.we;
      wr_addr = req_i.addr;
      wr_data = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re && !clr_busy_q) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = !clr_busy_q;

  a_no_req_during_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req_i.we && !req_i.re)
    else $error("store request during erase sweep");

  a_erase_ends_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("erase sweep restarted");

  a_erase_end_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> clr_addr_q == '0)
    else $error("erase sweep ended early");

endmodule

/* rtl/core/i2cee_rxbuf.sv */
`timescale 1ns / 1ps

module i2cee_rxbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cee_pkg::rxb_req_t req_i,
  output logic [7:0]          rdata_o
);
  import i2cee_pkg::*;

  logic [7:0] buf_mem [RxBufBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      buf_mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= buf_mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.we |-> !req_i.re)
    else $error("receive buffer written while draining");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.re |-> req_i.raddr >= IdxW'(AddrBytes))
    else $error("drain read of address byte");

  a_no_back_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(req_i.re) |-> !req_i.we)
    else $error("receive buffer written during drain");

endmodule

/* rtl/core/i2cee_ctrl.sv */
`timescale 1ns / 1ps

module i2cee_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          data_byte_i,
  input  logic                txn_ok_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          read_data_o,
  output logic                status_o,
  output logic                ready_res_o,
  input  logic                init_done_i,
  output i2cee_pkg::mem_req_t mem_req_o,
  input  logic [7:0]          mem_rdata_i,
  output i2cee_pkg::rxb_req_t rxb_req_o,
  input  logic [7:0]          rxb_rdata_i
);
  import i2cee_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_CMT  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic             ready_q, ready_d;
  logic             wphase_q, wphase_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cmt_left_q, cmt_left_d;
  logic             wr_pend_q, wr_pend_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       addr_hi_q, addr_hi_d;
  logic [7:0]       addr_lo_q, addr_lo_d;
  logic [IdxW-1:0]  cmt_idx_q, cmt_idx_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]       res_data_q, res_data_d;
  logic             res_status_q, res_status_d;
  logic             res_ready_q, res_ready_d;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_status_q, out_status_d;
  logic             out_ready_q, out_ready_d;

  logic             in_acc;
  logic             out_free;
  logic [15:0]      buf_addr;
  logic             buf_full;
  logic [IdxW-1:0]  wr_idx;
  logic             has_addr;

  assign in_stall_o = !(state_q == ST_IDLE) || !init_done_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign buf_addr   = {addr_hi_q, addr_lo_q};
  assign buf_full   = count_q >= CntW'(RxBufBytes);
  assign wr_idx     = buf_full ? IdxW'(AddrBytes) : count_q[IdxW-1:0];
  assign has_addr   = count_q >= CntW'(AddrBytes);

  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    wphase_d     = wphase_q;
    ovf_d        = ovf_q;
    count_d      = count_q;
    rptr_d       = rptr_q;
    cmt_left_d   = cmt_left_q;
    wr_pend_d    = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    addr_hi_d    = addr_hi_q;
    addr_lo_d    = addr_lo_q;
    cmt_idx_d    = cmt_idx_q;
    wr_addr_d    = wr_addr_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    res_ready_d  = res_ready_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_ready_d  = out_ready_q;
    mem_req_o    = '0;
    rxb_req_o    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_data_d   = 8'h00;
          res_status_d = 1'b0;
          state_d      = ST_PUSH;
          case (operation_i)
            OP_WR_START: begin
              ready_d  = 1'b0;
              wphase_d = 1'b1;
              ovf_d    = 1'b0;
              count_d  = '0;
            end
            OP_RD_START: begin
              ready_d = 1'b0;
              if (wphase_q && !has_addr) begin
                res_status_d = 1'b1;
              end else begin
                if (wphase_q) begin
                  rptr_d = buf_addr[AddrW-1:0];
                end
                wphase_d = 1'b0;
              end
            end
            OP_BYTE_RX: begin
              rxb_req_o.we    = 1'b1;
              rxb_req_o.waddr = wr_idx;
              rxb_req_o.wdata = data_byte_i;
              if (wr_idx == IdxW'(0)) begin
                addr_hi_d = data_byte_i;
              end
              if (wr_idx == IdxW'(1)) begin
                addr_lo_d = data_byte_i;
              end
              if (buf_full) begin
                ovf_d   = 1'b1;
                count_d = CntW'(AddrBytes + 1);
              end else begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_BYTE_TX: begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = rptr_q;
              rptr_d         = rptr_q + AddrW'(1);
              state_d        = ST_RD;
            end
            OP_STOP: begin
              if (txn_ok_i && wphase_q && has_addr) begin
                cmt_left_d = ovf_q ? CntW'(RxBufBytes - AddrBytes)
                                   : count_q - CntW'(AddrBytes);
                cmt_idx_d  = IdxW'(AddrBytes);
                wr_addr_d  = buf_addr[AddrW-1:0];
                state_d    = ST_CMT;
              end
              count_d  = '0;
              ovf_d    = 1'b0;
              wphase_d = 1'b0;
              ready_d  = 1'b1;
            end
            default: begin
            end
          endcase
          res_ready_d = ready_d;
        end
      end
      ST_RD: begin
        res_data_d = mem_rdata_i;
        state_d    = ST_PUSH;
      end
      ST_CMT: begin
        if (cmt_left_q != '0) begin
          rxb_req_o.re    = 1'b1;
          rxb_req_o.raddr = cmt_idx_q;
          cmt_idx_d       = cmt_idx_q + IdxW'(1);
          cmt_left_d      = cmt_left_q - CntW'(1);
          wr_pend_d       = 1'b1;
        end
        if (wr_pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = wr_addr_q;
          mem_req_o.wdata = rxb_rdata_i;
          wr_addr_d       = wr_addr_q + AddrW'(1);
        end
        if (cmt_left_q == '0 && !wr_pend_q) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          out_ready_d  = res_ready_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= 1'b1;
      wphase_q    <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      rptr_q      <= '0;
      cmt_left_q  <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      wphase_q    <= wphase_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
      rptr_q      <= rptr_d;
      cmt_left_q  <= cmt_left_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_hi_q    <= addr_hi_d;
    addr_lo_q    <= addr_lo_d;
    cmt_idx_q    <= cmt_idx_d;
    wr_addr_q    <= wr_addr_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    res_ready_q  <= res_ready_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_ready_q  <= out_ready_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;
  assign ready_res_o = out_ready_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE && init_done_i)
    else $error("request taken while busy");

  a_store_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> state_q == ST_CMT && $past(rxb_req_o.re))
    else $error("store write outside commit");

  a_read_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |=> state_q == ST_PUSH)
    else $error("read result not pushed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RxBufBytes))
    else $error("receive count beyond buffer");

  a_commit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMT |-> ready_q && !wphase_q && count_q == '0)
    else $error("commit with live transaction state");

endmodule

/* rtl/core/i2c_eeprom_slave_emulator.sv */
// flow: start, byte received, failed stop and unknown events register the result, then push it
//   to the output; byte requested goes through a registered store read first; a committing stop
//   first copies its data bytes one per cycle from the receive buffer into the store
// throughput: one request at a time; the next is taken once the previous result is registered
// reset: the store is erased to 0xff by a sweep over all 8192 bytes, during which no request is taken
`timescale 1ns / 1ps

module i2c_eeprom_slave_emulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic       txn_ok_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       status_o,
  output logic       ready_res_o
);
  import i2cee_pkg::*;

  mem_req_t   mem_req;
  rxb_req_t   rxb_req;
  logic [7:0] mem_rdata;
  logic [7:0] rxb_rdata;
  logic       init_done;

  i2cee_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rdata_o     (mem_rdata),
    .init_done_o (init_done)
  );

  i2cee_rxbuf u_rxbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rxb_req),
    .rdata_o (rxb_rdata)
  );

  i2cee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .txn_ok_i    (txn_ok_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .status_o    (status_o),
    .ready_res_o (ready_res_o),
    .init_done_i (init_done),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .rxb_req_o   (rxb_req),
    .rxb_rdata_i (rxb_rdata)
  );

endmodule

/* test/tb_i2c_eeprom_slave_emulator.sv */
`timescale 1ns / 1ps

module tb_i2c_eeprom_slave_emulator;
  import i2cee_pkg::*;

  localparam int QuietLimit = 4 * MemBytes;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic [7:0] rdata;
    logic       status;
    logic       ready;
  } eeprom_resp_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] operation_i;
  logic [7:0] data_byte_i;
  logic       txn_ok_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic       status_o;
  logic       ready_res_o;

  i2c_eeprom_slave_emulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .txn_ok_i    (txn_ok_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .status_o    (status_o),
    .ready_res_o (ready_res_o)
  );

  // shadow copy of the emulator state
  logic [7:0]       mem_shadow [MemBytes];
  logic [7:0]       rxbuf_shadow [RxBufBytes];
  int unsigned      rx_count_shadow;
  logic [AddrW-1:0] rd_ptr_shadow;
  bit               wr_phase_shadow;
  bit               overflow_shadow;
  bit               ready_shadow;

  eeprom_resp_t pending_resp_q [$];

  int err_cnt;
  int items_sent;
  int resp_checked;
  int commit_cnt;
  int overflow_commit_cnt;
  int bad_state_cnt;
  int quiet_cycles;
  int src_idle_pct;
  int snk_stall_pct;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_cnt++;
    $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic void reset_shadow();
    foreach (mem_shadow[i]) mem_shadow[i] = ErasedByte;
    foreach (rxbuf_shadow[i]) rxbuf_shadow[i] = 8'h00;
    rx_count_shadow = 0;
    rd_ptr_shadow   = '0;
    wr_phase_shadow = 1'b0;
    overflow_shadow = 1'b0;
    ready_shadow    = 1'b1;
  endfunction

  function automatic void commit_shadow();
    logic [15:0]      full_addr;
    logic [AddrW-1:0] waddr;
    int unsigned      n;
    if (rx_count_shadow < AddrBytes) return;
    n = overflow_shadow ? RxBufBytes - AddrBytes : rx_count_shadow - AddrBytes;
    full_addr = {rxbuf_shadow[0], rxbuf_shadow[1]};
    waddr = full_addr[AddrW-1:0];
    for (int unsigned i = 0; i < n; i++) begin
      mem_shadow[waddr] = rxbuf_shadow[AddrBytes + i];
      waddr++;
    end
    commit_cnt++;
    if (overflow_shadow) overflow_commit_cnt++;
  endfunction

  function automatic eeprom_resp_t eeprom_predict(input logic [2:0] op, input logic [7:0] data,
                                                  input logic ok);
    eeprom_resp_t r;
    logic [15:0]  full_addr;
    r = '0;
    case (op)
      OP_WR_START: begin
        ready_shadow    = 1'b0;
        wr_phase_shadow = 1'b1;
        overflow_shadow = 1'b0;
        rx_count_shadow = 0;
      end
      OP_RD_START: begin
        ready_shadow = 1'b0;
        if (wr_phase_shadow && rx_count_shadow < AddrBytes) begin
          r.status = 1'b1;
          bad_state_cnt++;
        end else begin
          if (wr_phase_shadow) begin
            full_addr = {rxbuf_shadow[0], rxbuf_shadow[1]};
            rd_ptr_shadow = full_addr[AddrW-1:0];
          end
          wr_phase_shadow = 1'b0;
        end
      end
      OP_BYTE_RX: begin
        if (rx_count_shadow >= RxBufBytes) begin
          overflow_shadow = 1'b1;
          rx_count_shadow = AddrBytes;
        end
        rxbuf_shadow[rx_count_shadow] = data;
        rx_count_shadow++;
      end
      OP_BYTE_TX: begin
        r.rdata = mem_shadow[rd_ptr_shadow];
        rd_ptr_shadow++;
      end
      OP_STOP: begin
        if (ok && wr_phase_shadow) commit_shadow();
        foreach (rxbuf_shadow[i]) rxbuf_shadow[i] = 8'h00;
        rx_count_shadow = 0;
        overflow_shadow = 1'b0;
        wr_phase_shadow = 1'b0;
        ready_shadow    = 1'b1;
      end
      default: ;
    endcase
    r.ready = ready_shadow;
    return r;
  endfunction

  // result checking, prediction on acceptance, and the watchdog
  always @(posedge clk_i) begin
    eeprom_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_resp_q.size() == 0) begin
          report_mismatch("unexpected result", 32'({read_data_o, status_o, ready_res_o}), 0);
        end else begin
          want = pending_resp_q.pop_front();
          resp_checked++;
          if (read_data_o !== want.rdata)
            report_mismatch("read_data", 32'(read_data_o), 32'(want.rdata));
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (ready_res_o !== want.ready)
            report_mismatch("ready_res", 32'(ready_res_o), 32'(want.ready));
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_resp_q.push_back(eeprom_predict(operation_i, data_byte_i, txn_ok_i));
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: random stall, or a long counted hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        repeat (HoldCycles) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  task automatic send_req(input logic [2:0] op, input logic [7:0] data, input logic ok);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= data;
    txn_ok_i    <= ok;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (op <= OP_STOP) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_resp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_addr(output logic [7:0] hi, output logic [7:0] lo);
    case ($urandom_range(3))
      0: hi = 8'h00;
      1: hi = 8'hFF;
      2: hi = 8'h1F;
      default: hi = 8'($urandom_range(255));
    endcase
    lo = 8'($urandom_range(255));
  endtask

  task automatic write_txn();
    logic [7:0] hi, lo;
    int n;
    pick_addr(hi, lo);
    n = ($urandom_range(11) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 8);
    send_req(OP_WR_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    send_req(OP_BYTE_RX, hi, 1'($urandom_range(1)));
    send_req(OP_BYTE_RX, lo, 1'($urandom_range(1)));
    repeat (n) send_req(OP_BYTE_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
    send_req(OP_STOP, 8'($urandom_range(255)), $urandom_range(9) != 0);
  endtask

  task automatic read_txn(input bit with_addr);
    logic [7:0] hi, lo;
    pick_addr(hi, lo);
    if (with_addr) begin
      send_req(OP_WR_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_req(OP_BYTE_RX, hi, 1'($urandom_range(1)));
      send_req(OP_BYTE_RX, lo, 1'($urandom_range(1)));
    end
    send_req(OP_RD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat ($urandom_range(1, 6))
      send_req(OP_BYTE_TX, 8'($urandom_range(255)), 1'($urandom_range(1)));
    send_req(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic broken_txn();
    send_req(OP_WR_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat ($urandom_range(1))
      send_req(OP_BYTE_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
    if ($urandom_range(1)) begin
      send_req(OP_RD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
      repeat ($urandom_range(2))
        send_req(OP_BYTE_TX, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    send_req(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_directed_events();
    // erased store, read without a preceding write
    send_req(OP_BYTE_TX, 8'h00, 1'b0);
    send_req(OP_RD_START, 8'hFF, 1'b1);
    send_req(OP_BYTE_TX, 8'hFF, 1'b1);
    send_req(OP_STOP, 8'h00, 1'b1);
    // read start with only one address byte
    send_req(OP_WR_START, 8'h00, 1'b0);
    send_req(OP_BYTE_RX, 8'hFF, 1'b0);
    send_req(OP_RD_START, 8'h00, 1'b0);
    send_req(OP_STOP, 8'h00, 1'b0);
    // write at the top address, wrapping to zero
    send_req(OP_WR_START, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'hFF, 1'b1);
    send_req(OP_BYTE_RX, 8'hFF, 1'b1);
    send_req(OP_BYTE_RX, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'hFF, 1'b1);
    send_req(OP_BYTE_RX, 8'h5A, 1'b1);
    send_req(OP_STOP, 8'h00, 1'b1);
    // failed stop drops the data
    send_req(OP_WR_START, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'hA5, 1'b1);
    send_req(OP_STOP, 8'hFF, 1'b0);
    // read back across the wrap
    send_req(OP_WR_START, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'hFF, 1'b1);
    send_req(OP_BYTE_RX, 8'hFF, 1'b1);
    send_req(OP_RD_START, 8'h00, 1'b1);
    repeat (3) send_req(OP_BYTE_TX, 8'h00, 1'b1);
    send_req(OP_STOP, 8'h00, 1'b1);
    // unknown codes, and a byte outside a write
    send_req(3'd5, 8'hFF, 1'b1);
    send_req(3'd6, 8'h00, 1'b0);
    send_req(3'd7, 8'hFF, 1'b1);
    send_req(OP_BYTE_RX, 8'h3C, 1'b0);
    send_req(OP_STOP, 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    int kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 40) write_txn();
      else if (kind < 70) read_txn(1'b1);
      else if (kind < 80) read_txn(1'b0);
      else if (kind < 90) broken_txn();
      else
        repeat ($urandom_range(1, 3))
          send_req(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_output_hold_off();
    wait_drained();
    hold_req = 1'b1;
    send_req(OP_WR_START, 8'h00, 1'b1);
    send_req(OP_BYTE_RX, 8'h10, 1'b1);
    send_req(OP_BYTE_RX, 8'h00, 1'b1);
    repeat (16) send_req(OP_BYTE_RX, 8'($urandom_range(255)), 1'b1);
    send_req(OP_STOP, 8'h00, 1'b1);
    read_txn(1'b1);
    wait_drained();
  endtask

  initial begin
    in_valid_i  = 1'b0;
    operation_i = OP_STOP;
    data_byte_i = 8'h00;
    txn_ok_i    = 1'b0;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    src_idle_pct  = 21;
    snk_stall_pct = 49;
    reset_shadow();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_events();
    test_random_traffic(360);
    src_idle_pct  = 49;
    snk_stall_pct = 21;
    test_random_traffic(360);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_traffic(360);
    src_idle_pct  = 21;
    test_output_hold_off();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d bus events, %0d results checked: directed edge cases, random",
             items_sent, resp_checked);
    $display("transactions with %0d commits (%0d after overflow), %0d bad-state reads, hold-off",
             commit_cnt, overflow_commit_cnt, bad_state_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
